// File: rtl/psfc_pkg.sv
// constants, control struct and widths for the prime sieve filter chain
// no dependencies; imported by psfc_cell and prime_sieve_filter_chain_core
package psfc_pkg;

    // field widths
    localparam int CAND_W     = 16;
    localparam int LIMIT_W    = 9;

    // chain capacity: one cell for each prime that can be stored
    localparam int MAX_PRIMES = 256;
    localparam int CELL_IDX_W = $clog2(MAX_PRIMES);
    localparam int COUNT_W    = $clog2(MAX_PRIMES + 1);

    // limit register defaults and saturation
    localparam logic [LIMIT_W-1:0] DEFAULT_LIMIT = LIMIT_W'(100);
    localparam logic [COUNT_W-1:0] MAX_COUNT     = COUNT_W'(MAX_PRIMES);

    // smallest candidate that can be prime
    localparam logic [CAND_W-1:0]  MIN_CAND      = CAND_W'(2);

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic               clear;   // start of a candidate: zero remainder and hit
        logic               step;    // one restoring-division digit
        logic               digit;   // candidate bit for this step, msb first
        logic               ripple;  // move hit flags one cell toward cell 0
        logic               store;   // write the candidate into the first free cell
        logic [COUNT_W-1:0] count;   // number of primes stored
        logic [CAND_W-1:0]  cand;    // candidate value to store
    } psfc_ctrl_t;

endpackage

// File: rtl/psfc_cell.sv
// one filter cell: holds one stored prime, forms candidate mod prime bit-serially
// and passes a divisibility flag to its lower neighbor; uses psfc_pkg
module psfc_cell
    import psfc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [CELL_IDX_W-1:0] cell_idx,
    input  psfc_ctrl_t            ctrl,
    input  logic                  hit_in,
    output logic                  hit_out
);

    logic [CAND_W-1:0] prime_reg;
    logic [CAND_W-1:0] rem_reg;
    logic [CAND_W-1:0] rem_next;
    logic              hit_reg;
    logic              hit_next;
    logic [CAND_W:0]   trial;
    logic              active;
    logic              write_here;

    // this cell holds a prime once the count has passed it
    assign active     = COUNT_W'(cell_idx) < ctrl.count;
    assign write_here = ctrl.store && (ctrl.count == COUNT_W'(cell_idx));

    // restoring division step: shift in one digit, subtract if it fits
    always_comb begin
        trial = {rem_reg, ctrl.digit};
        if (trial >= {1'b0, prime_reg}) begin
            rem_next = CAND_W'(trial - {1'b0, prime_reg});
        end else begin
            rem_next = trial[CAND_W-1:0];
        end
    end

    // hit flag: own zero remainder or anything coming from above
    always_comb begin
        hit_next = hit_reg;
        if (ctrl.clear) begin
            hit_next = 1'b0;
        end else if (ctrl.ripple) begin
            hit_next = hit_in || (active && (rem_reg == '0));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else begin
            hit_reg <= hit_next;
        end
    end

    // remainder and stored prime
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            rem_reg <= '0;
        end else if (ctrl.step) begin
            rem_reg <= rem_next;
        end
        if (write_here) begin
            prime_reg <= ctrl.cand;
        end
    end

    assign hit_out = hit_reg;

endmodule

// File: rtl/prime_sieve_filter_chain_core.sv
// top level of the prime sieve filter chain: sequencer, limit register,
// output register and the row of psfc_cell filters; uses psfc_pkg
//
//   port group   dir  handshake          payload
//   s_           in   s_valid / s_ready  s_candidate
//   m_           out  m_valid / m_ready  m_prime_value, m_prime_index, m_final_prime
//   cfg_         in   cfg_wr_en          cfg_wr_data (prime_limit)
//
// one candidate at a time: accept in ST_IDLE, the restoring-division steps in all cells at once
// in ST_DIVIDE, then ST_RIPPLE while the hit flags ripple down to cell 0 (skipped while no prime
// is stored), then the decision in ST_DECIDE.
// a candidate below 2, or one arriving after the limit is reached, is dropped on accept.
// the output register frees the chain: a new beat is taken while a result waits;
// only a new prime meeting a full, stalled output register waits in the decision cycle.
// aresetn clears count, limit (to 100), sequencer and output valid; no clearing pass.
module prime_sieve_filter_chain_core
    import psfc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CAND_W-1:0]  s_candidate,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CAND_W-1:0]  m_prime_value,
    output logic [LIMIT_W-1:0] m_prime_index,
    output logic               m_final_prime,
    input  logic               cfg_wr_en,
    input  logic [LIMIT_W-1:0] cfg_wr_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_RIPPLE,
        ST_DECIDE
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [CAND_W-1:0]  cand_reg, cand_next;
    logic [CAND_W-1:0]  shift_reg, shift_next;
    logic               m_valid_reg, m_valid_next;
    logic [CAND_W-1:0]  m_value_reg, m_value_next;
    logic [LIMIT_W-1:0] m_index_reg, m_index_next;
    logic               m_final_reg, m_final_next;

    logic [COUNT_W-1:0] eff_limit;
    logic [COUNT_W-1:0] count_inc;
    logic               out_free;
    logic               accept;
    psfc_ctrl_t         ctrl;
    logic               hit_link [0:MAX_PRIMES];

    // effective limit: zero means the default, capped at chain capacity
    always_comb begin
        if (limit_reg == '0) begin
            eff_limit = COUNT_W'(DEFAULT_LIMIT);
        end else if (COUNT_W'(limit_reg) > MAX_COUNT) begin
            eff_limit = MAX_COUNT;
        end else begin
            eff_limit = COUNT_W'(limit_reg);
        end
    end

    assign count_inc = count_reg + COUNT_W'(1);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        count_next   = count_reg;
        cand_next    = cand_reg;
        shift_next   = shift_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_value_next = m_value_reg;
        m_index_next = m_index_reg;
        m_final_next = m_final_reg;

        ctrl        = '0;
        ctrl.count  = count_reg;
        ctrl.cand   = cand_reg;
        ctrl.digit  = shift_reg[CAND_W-1];

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (count_reg < eff_limit) && (s_candidate >= MIN_CAND)) begin
                    cand_next  = s_candidate;
                    shift_next = s_candidate;
                    cnt_next   = '0;
                    ctrl.clear = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                ctrl.step  = 1'b1;
                shift_next = {shift_reg[CAND_W-2:0], 1'b0};
                if (cnt_reg == COUNT_W'(CAND_W - 1)) begin
                    cnt_next   = '0;
                    state_next = (count_reg == '0) ? ST_DECIDE : ST_RIPPLE;
                end else begin
                    cnt_next = cnt_reg + COUNT_W'(1);
                end
            end
            ST_RIPPLE: begin
                ctrl.ripple = 1'b1;
                if (cnt_reg == count_reg - COUNT_W'(1)) begin
                    cnt_next   = '0;
                    state_next = ST_DECIDE;
                end else begin
                    cnt_next = cnt_reg + COUNT_W'(1);
                end
            end
            ST_DECIDE: begin
                if (hit_link[0]) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    ctrl.store   = 1'b1;
                    count_next   = count_inc;
                    m_valid_next = 1'b1;
                    m_value_next = cand_reg;
                    m_index_next = LIMIT_W'(count_inc);
                    m_final_next = (count_inc == eff_limit);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            count_reg   <= '0;
            limit_reg   <= DEFAULT_LIMIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
        cand_reg    <= cand_next;
        shift_reg   <= shift_next;
        m_value_reg <= m_value_next;
        m_index_reg <= m_index_next;
        m_final_reg <= m_final_next;
    end

    // filter chain: hit flags travel from high cells toward cell 0
    assign hit_link[MAX_PRIMES] = 1'b0;

    for (genvar gi = 0; gi < MAX_PRIMES; gi++) begin : g_cell
        psfc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (CELL_IDX_W'(gi)),
            .ctrl     (ctrl),
            .hit_in   (hit_link[gi + 1]),
            .hit_out  (hit_link[gi])
        );
    end

    assign m_valid       = m_valid_reg;
    assign m_prime_value = m_value_reg;
    assign m_prime_index = m_index_reg;
    assign m_final_prime = m_final_reg;

    // a waiting beat always carries the index of the newest stored prime
    a_index_tracks_count: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_prime_index == LIMIT_W'(count_reg))
    ) else $error("output index out of step with stored count");

    // a candidate taken after the limit is reached starts no work
    a_drop_at_limit: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (accept && (count_reg >= eff_limit)) |=> (state_reg == ST_IDLE)
    ) else $error("candidate processed past the limit");

    // the stored count never runs past the chain length
    a_count_in_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_COUNT
    ) else $error("stored prime count beyond chain capacity");

    // a surviving candidate with room at the output becomes a result next cycle
    a_store_emits: assert property (
        @(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DECIDE) && !hit_link[0] && out_free)
            |=> (m_valid && (count_reg == $past(count_inc)))
    ) else $error("new prime not emitted");

endmodule

// File: test/tb_prime_sieve_filter_chain_core.sv
// self-checking testbench for prime_sieve_filter_chain_core: directed and random candidates,
// a sieve predictor and an in-order beat checker
// depends on rtl/psfc_pkg.sv and rtl/prime_sieve_filter_chain_core.sv
`timescale 1ns / 100ps

module tb_prime_sieve_filter_chain_core
    import psfc_pkg::*;
();

    localparam int unsigned RESET_CYCLES   = 11;
    localparam int unsigned CHAIN_BASE_LAT = 18;
    localparam int unsigned CYCLE_LIMIT    = 4_000_000;
    localparam int unsigned STALL_CYCLES   = 3000;
    localparam int unsigned STALL_BEATS    = 40;

    typedef struct packed {
        logic [CAND_W-1:0]  value;
        logic [LIMIT_W-1:0] index;
        logic               last;
    } prime_beat_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               s_valid     = 1'b0;
    logic [CAND_W-1:0]  s_candidate = '0;
    logic               m_ready     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [LIMIT_W-1:0] cfg_wr_data = '0;
    logic               s_ready;
    logic               m_valid;
    logic [CAND_W-1:0]  m_prime_value;
    logic [LIMIT_W-1:0] m_prime_index;
    logic               m_final_prime;

    // sieve predictor state
    logic [CAND_W-1:0]  sieve_table [MAX_PRIMES];
    int unsigned        sieve_fill   = 0;
    logic [LIMIT_W-1:0] limit_shadow = DEFAULT_LIMIT;
    prime_beat_t        expected_primes [$];
    prime_beat_t        oldest_prime;

    int unsigned tested_items   = 0;
    int unsigned sent_items     = 0;
    int unsigned primes_checked = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned tx_idle_pct    = 0;
    int unsigned rx_idle_pct    = 0;
    int unsigned rx_hold_left   = 0;
    int unsigned seq_cursor     = 19;

    always #5 aclk = ~aclk;

    prime_sieve_filter_chain_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_candidate   (s_candidate),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_prime_value (m_prime_value),
        .m_prime_index (m_prime_index),
        .m_final_prime (m_final_prime),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // zero means the default count, anything past the chain saturates
    function automatic int unsigned limit_in_force();
        int unsigned lim;
        lim = limit_shadow;
        if (lim == 0) lim = DEFAULT_LIMIT;
        if (lim > MAX_PRIMES) lim = MAX_PRIMES;
        return lim;
    endfunction

    // test one accepted candidate against the stored primes, queue the beat it yields
    function automatic void sieve_candidate(input logic [CAND_W-1:0] cand);
        int unsigned lim;
        bit          divides;
        prime_beat_t beat;
        lim = limit_in_force();
        if (sieve_fill >= lim || cand < MIN_CAND) return;
        tested_items++;
        divides = 1'b0;
        for (int unsigned i = 0; i < sieve_fill; i++) begin
            if (cand % sieve_table[i] == 0) divides = 1'b1;
        end
        if (divides) return;
        sieve_table[sieve_fill] = cand;
        sieve_fill++;
        beat.value = cand;
        beat.index = LIMIT_W'(sieve_fill);
        beat.last  = (sieve_fill == lim);
        expected_primes.push_back(beat);
    endfunction

    // mostly the ascending odd stream and multiples of stored primes, some noise
    function automatic logic [CAND_W-1:0] random_candidate();
        int unsigned pick;
        int unsigned p;
        int unsigned c;
        pick = $urandom_range(0, 99);
        if (pick < 45 || sieve_fill == 0) begin
            c = seq_cursor;
            seq_cursor += ($urandom_range(0, 4) == 0) ? 2 * $urandom_range(2, 5) : 2;
            if (seq_cursor > 65533) seq_cursor = 3;
        end else if (pick < 85) begin
            p = sieve_table[$urandom_range(0, sieve_fill - 1)];
            c = (p <= 32767) ? p * $urandom_range(2, 65535 / p) : p;
        end else if (pick < 92) begin
            c = $urandom_range(0, 65535);
        end else if (pick < 96) begin
            c = $urandom_range(0, 1);
        end else begin
            c = sieve_table[$urandom_range(0, sieve_fill - 1)];
        end
        return CAND_W'(c);
    endfunction

    // offer one candidate beat, hold it until taken
    task automatic send_candidate(input logic [CAND_W-1:0] cand);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_candidate <= cand;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_items++;
        sieve_candidate(cand);
    endtask

    // all primes out, then room for a composite still in the chain
    task automatic settle_chain();
        s_valid <= 1'b0;
        while (expected_primes.size() != 0) @(posedge aclk);
        repeat (CHAIN_BASE_LAT + sieve_fill + 8) @(posedge aclk);
    endtask

    task automatic write_prime_limit(input logic [LIMIT_W-1:0] lim);
        settle_chain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        limit_shadow = lim;
    endtask

    task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
        @(negedge aclk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        @(posedge aclk);
    endtask

    // limit of one: single prime with the last flag, small candidates and later ones dropped
    task automatic test_lowest_limit();
        write_prime_limit(LIMIT_W'(1));
        send_candidate(CAND_W'(0));
        send_candidate(CAND_W'(1));
        send_candidate(CAND_W'(2));
        send_candidate(CAND_W'(3));
    endtask

    // zero limit falls back to the default; repeats, out-of-order and extreme values
    task automatic test_default_limit_and_order();
        logic [CAND_W-1:0] cands [14] = '{2, 9, 3, 15, 4, 5, 7, 25, 65535, 65521,
                                          32768, 11, 13, 1};
        write_prime_limit(LIMIT_W'(0));
        foreach (cands[i]) send_candidate(cands[i]);
    endtask

    // limit dropped below the stored count stops output, restoring it resumes
    task automatic test_limit_lowered();
        write_prime_limit(LIMIT_W'(5));
        send_candidate(CAND_W'(17));
        send_candidate(CAND_W'(19));
        write_prime_limit(LIMIT_W'(0));
        send_candidate(CAND_W'(17));
    endtask

    task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                       input logic [LIMIT_W-1:0] lim,
                                       input int unsigned target);
        int unsigned start;
        write_prime_limit(lim);
        set_idling(tx_pct, rx_pct);
        start = tested_items;
        while (tested_items - start < target && sieve_fill < limit_in_force()) begin
            send_candidate(random_candidate());
        end
    endtask

    // receiver stalls for a long stretch while the ascending stream keeps coming
    task automatic test_output_backpressure();
        write_prime_limit(LIMIT_W'(511));
        set_idling(0, 0);
        @(negedge aclk);
        rx_hold_left = STALL_CYCLES;
        @(posedge aclk);
        repeat (STALL_BEATS) begin
            send_candidate(CAND_W'(seq_cursor));
            seq_cursor += 2;
        end
    endtask

    // receiver: long hold when requested (set at negedge only), else random idling
    always @(posedge aclk) begin
        if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // compare each prime beat with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_primes.size() == 0) begin
                $error("unexpected prime beat: value %0d index %0d", m_prime_value,
                       m_prime_index);
                error_count++;
            end else begin
                oldest_prime = expected_primes.pop_front();
                primes_checked++;
                if (m_prime_value !== oldest_prime.value) begin
                    $error("prime_value: expected %0d, got %0d", oldest_prime.value,
                           m_prime_value);
                    error_count++;
                end
                if (m_prime_index !== oldest_prime.index) begin
                    $error("prime_index: expected %0d, got %0d", oldest_prime.index,
                           m_prime_index);
                    error_count++;
                end
                if (m_final_prime !== oldest_prime.last) begin
                    $error("final_prime: expected %0d, got %0d", oldest_prime.last,
                           m_final_prime);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d primes outstanding", cycle_count,
                     expected_primes.size());
            $display("tb_prime_sieve_filter_chain_core NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_lowest_limit();
        test_default_limit_and_order();
        test_limit_lowered();
        test_random_traffic(12, 66, LIMIT_W'(90), 500);
        test_random_traffic(66, 12, LIMIT_W'(170), 550);
        test_output_backpressure();
        test_random_traffic(0, 0, LIMIT_W'(256), 600);
        settle_chain();
        // late or stray beats would land here
        repeat (CHAIN_BASE_LAT + MAX_PRIMES) @(posedge aclk);
        $display("sent %0d candidates, %0d tested by the chain, %0d prime beats checked",
                 sent_items, tested_items, primes_checked);
        $display("limits 1, 0, 5, 90, 170, 511 and 256; idling both ways, long output stall");
        if (error_count == 0) begin
            $display("tb_prime_sieve_filter_chain_core OK");
        end else begin
            $display("tb_prime_sieve_filter_chain_core NOT OK");
        end
        $finish;
    end

endmodule
